FILE: rtl/keyed_multi_queue_fifo_top_assert.svh
// ----------------------------------------------------------------------------
// Keyed multi-queue FIFO assertion macros
// Clocked, reset-qualified property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef KEYED_MULTI_QUEUE_FIFO_TOP_ASSERT_SVH
`define KEYED_MULTI_QUEUE_FIFO_TOP_ASSERT_SVH

// Same-cycle implication.
`define KMQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kmq_pkg.sv
// ----------------------------------------------------------------------------
// Keyed multi-queue FIFO package
// Widths, codes and shared types of the keyed multi-queue FIFO.
// ----------------------------------------------------------------------------
package kmq_pkg;

  localparam int NUM_QUEUES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 128;

  localparam int KEY_W = 32;
  localparam int AMT_W = 16;
  localparam int ST_W  = 3;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_UNKNOWN,
    ST_TABLE_FULL
  } status_e;

  typedef struct packed {
    logic hit;
    logic full;
  } lookup_t;

endpackage

FILE: rtl/kmq_if.sv
// ----------------------------------------------------------------------------
// Keyed multi-queue FIFO channels
// Command and result channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface kmq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [kmq_pkg::KEY_W-1:0] queue_key;
  logic [kmq_pkg::AMT_W-1:0] order_amount;

  modport source (output valid, cmd, queue_key, order_amount, input ready);
  modport sink   (input valid, cmd, queue_key, order_amount, output ready);
endinterface

interface kmq_out_if;
  logic                      valid;
  logic                      ready;
  logic [kmq_pkg::AMT_W-1:0] head_amount;
  logic [kmq_pkg::ST_W-1:0]  status;

  modport source (output valid, head_amount, status, input ready);
  modport sink   (input valid, head_amount, status, output ready);
endinterface

FILE: rtl/kmq_key_match.sv
// ----------------------------------------------------------------------------
// Keyed multi-queue FIFO key table
// Parallel key compare over valid entries and in-order entry allocation.
// ----------------------------------------------------------------------------
module kmq_key_match #(
  parameter int  NUM_QUEUES = kmq_pkg::NUM_QUEUES_DEF,
  localparam int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kmq_pkg::KEY_W-1:0] key_i,
  output kmq_pkg::lookup_t          lookup_o,
  output logic [QW-1:0]             idx_o,
  output logic [QW-1:0]             free_idx_o,
  input  logic                      alloc_i,
  input  logic [kmq_pkg::KEY_W-1:0] alloc_key_i
);

  localparam int CW = $clog2(NUM_QUEUES + 1);

  logic [kmq_pkg::KEY_W-1:0] key_q [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]     valid_q;
  logic [CW-1:0]             free_q;
  logic [NUM_QUEUES-1:0]     hit_vec;

  assign free_idx_o = free_q[QW-1:0];

  // keys are unique, so the hit vector is one-hot and an OR gives the index
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == key_i);
      if (hit_vec[i]) begin
        idx_o = idx_o | QW'(i);
      end
    end
    lookup_o.hit  = |hit_vec;
    lookup_o.full = (free_q == CW'(NUM_QUEUES));
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      key_q[free_idx_o] <= alloc_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      free_q  <= '0;
    end else if (alloc_i) begin
      valid_q[free_idx_o] <= 1'b1;
      free_q              <= free_q + CW'(1);
    end
  end

endmodule

FILE: rtl/kmq_ram.sv
// ----------------------------------------------------------------------------
// Keyed multi-queue FIFO RAM
// Simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module kmq_ram #(
  parameter int  WIDTH = kmq_pkg::AMT_W,
  parameter int  DEPTH = kmq_pkg::NUM_QUEUES_DEF * kmq_pkg::QUEUE_DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/keyed_multi_queue_fifo_top.sv
// ----------------------------------------------------------------------------
// Keyed multi-queue FIFO
// One ring-buffer FIFO per 32-bit key, all sharing one order store.
// ----------------------------------------------------------------------------
// Each command (enqueue or dequeue) names a queue by key; the key table is
// compared in parallel and an enqueue to an unknown key takes the next free
// table entry. Every command yields exactly one result with a status. A
// command passes from its input transfer to its result entering the output
// register in steps: key match and pointer memory read at the transfer, then
// pointer update, then result handoff; a dequeue that returns data adds the
// order store read before the handoff. The next command is taken the cycle
// after the handoff, so a new command is not accepted while one is in
// flight. A result waiting in the output register does not block the next
// command, only the following handoff.
// ----------------------------------------------------------------------------
module keyed_multi_queue_fifo_top #(
  parameter int NUM_QUEUES  = kmq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = kmq_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  kmq_in_if.sink     in_i,
  kmq_out_if.source  out_o
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PW    = 2 * PTR_W + CNT_W;
  localparam int ODEP  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int OAW   = $clog2(ODEP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  logic                      cmd_q;
  logic [kmq_pkg::KEY_W-1:0] key_q;
  logic [kmq_pkg::AMT_W-1:0] amt_q;
  logic [QW-1:0]             qidx_q;
  logic                      hit_q;
  logic                      full_q;

  logic [kmq_pkg::AMT_W-1:0] res_amt_q, res_amt_d;
  kmq_pkg::status_e          res_st_q, res_st_d;

  logic                      out_valid_q;
  logic [kmq_pkg::AMT_W-1:0] out_amt_q;
  kmq_pkg::status_e          out_st_q;

  kmq_pkg::lookup_t lk;
  logic [QW-1:0]    match_idx, free_idx;
  logic             in_fire, alloc;

  logic [PW-1:0]    ptr_rdata, ptr_wdata;
  logic             ptr_we;
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] cnt;

  logic                      ord_we, ord_re;
  logic [OAW-1:0]            ord_waddr, ord_raddr;
  logic [kmq_pkg::AMT_W-1:0] ord_rdata;
  logic                      out_load;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [OAW-1:0] slot(input logic [QW-1:0] q,
                                          input logic [PTR_W-1:0] p);
    return OAW'(q) * OAW'(QUEUE_DEPTH) + OAW'(p);
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  kmq_key_match #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_key_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (in_i.queue_key),
    .lookup_o    (lk),
    .idx_o       (match_idx),
    .free_idx_o  (free_idx),
    .alloc_i     (alloc),
    .alloc_key_i (key_q)
  );

  kmq_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_QUEUES)
  ) u_ptr_mem (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (qidx_q),
    .wdata_i (ptr_wdata),
    .re_i    (in_fire),
    .raddr_i (lk.hit ? match_idx : free_idx),
    .rdata_o (ptr_rdata)
  );

  kmq_ram #(
    .WIDTH (kmq_pkg::AMT_W),
    .DEPTH (ODEP)
  ) u_order_mem (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (amt_q),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // a freshly allocated entry starts from empty pointers
  always_comb begin
    if (!hit_q) begin
      head = '0;
      tail = '0;
      cnt  = '0;
    end else begin
      {head, tail, cnt} = ptr_rdata;
    end
  end

  assign ord_waddr = slot(qidx_q, tail);
  assign ord_raddr = slot(qidx_q, head);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    res_amt_d = res_amt_q;
    res_st_d  = res_st_q;
    ptr_we    = 1'b0;
    ptr_wdata = {head, tail, cnt};
    ord_we    = 1'b0;
    ord_re    = 1'b0;
    alloc     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_amt_d = '0;
        state_d   = S_DONE;
        if (cmd_q == kmq_pkg::CMD_ENQ) begin
          if (!hit_q && full_q) begin
            res_st_d = kmq_pkg::ST_TABLE_FULL;
          end else if (cnt == CNT_W'(QUEUE_DEPTH)) begin
            res_st_d = kmq_pkg::ST_FULL;
          end else begin
            res_st_d  = kmq_pkg::ST_OK;
            ord_we    = 1'b1;
            ptr_we    = 1'b1;
            ptr_wdata = {head, advance(tail), cnt + CNT_W'(1)};
            alloc     = !hit_q;
          end
        end else begin
          if (!hit_q) begin
            res_st_d = kmq_pkg::ST_UNKNOWN;
          end else if (cnt == '0) begin
            res_st_d = kmq_pkg::ST_EMPTY;
          end else begin
            res_st_d  = kmq_pkg::ST_OK;
            ord_re    = 1'b1;
            ptr_we    = 1'b1;
            ptr_wdata = {advance(head), tail, cnt - CNT_W'(1)};
            state_d   = S_READ;
          end
        end
      end
      S_READ: begin
        res_amt_d = ord_rdata;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_i.cmd;
      key_q  <= in_i.queue_key;
      amt_q  <= in_i.order_amount;
      qidx_q <= lk.hit ? match_idx : free_idx;
      hit_q  <= lk.hit;
      full_q <= lk.full;
    end
    res_amt_q <= res_amt_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_amt_q <= res_amt_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.head_amount = out_amt_q;
  assign out_o.status      = out_st_q;

`include "keyed_multi_queue_fifo_top_assert.svh"

  `KMQ_ASSERT_NEXT(a_fire_to_exec, in_fire, state_q == S_EXEC, "transfer not executed")
  `KMQ_ASSERT_NOW(a_cnt_bound, ptr_we, ptr_wdata[CNT_W-1:0] <= CNT_W'(QUEUE_DEPTH), "count overflow")
  `KMQ_ASSERT_NOW(a_read_on_hit, ord_re, (cmd_q == kmq_pkg::CMD_DEQ) && hit_q, "read without hit")
  `KMQ_ASSERT_NOW(a_alloc_room, alloc, !full_q && !hit_q && (cmd_q == kmq_pkg::CMD_ENQ), "bad alloc")

endmodule
